@@ rtl/ostk_pkg.sv @@
`timescale 1ns / 1ps

package ostk_pkg;

    localparam int WORD_W  = 64;
    localparam int CNT_W   = 7;
    localparam int FILL_W  = 7;
    localparam int CMD_W   = 3;
    localparam int ERR_W   = 2;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_SWAP  = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FEW   = 2'd2,
        ERR_FULL  = 2'd3
    } err_t;

    // what every cell does when clocked
    typedef enum logic [2:0] {
        OP_HOLD = 3'd0,
        OP_PUSH = 3'd1,
        OP_POP  = 3'd2,
        OP_SWAP = 3'd3,
        OP_ROT  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wrap;   // this cell holds the bottom entry
    } cell_ctrl_t;

endpackage

@@ rtl/ostk_cell.sv @@
`timescale 1ns / 1ps

module ostk_cell
    import ostk_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] prev,    // neighbor nearer the top, or the pushed word
    input  logic [WORD_W-1:0] next,    // neighbor farther from the top
    input  logic [WORD_W-1:0] top,     // word in cell 0
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_PUSH: data_next = prev;
            OP_POP:  data_next = next;
            OP_SWAP:
            begin
                if (IDX == 0)
                    data_next = next;
                else if (IDX == 1)
                    data_next = prev;
            end
            // advance toward the top; the bottom entry takes the old top
            OP_ROT:  data_next = ctrl.wrap ? top : next;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;

endmodule

@@ rtl/ostk_seq.sv @@
`timescale 1ns / 1ps

module ostk_seq
    import ostk_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int FW    = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic                quiet,
    input  logic [CNT_W-1:0]    count,
    input  logic [WORD_W-1:0]   top,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [WORD_W-1:0]   out_data,
    output logic                out_dv,
    output logic [ERR_W-1:0]    out_err,
    output logic                out_chg,
    output logic [FILL_W-1:0]   out_fill,
    output logic                out_last,
    output cell_op_t            op,
    output logic [FW-1:0]       fill
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       rd_left_reg, rd_left_next;
    logic [FW-1:0]       rot_left_reg, rot_left_next;
    logic                valid_reg, valid_next;
    logic [WORD_W-1:0]   data_reg, data_next;
    logic                dv_reg, dv_next;
    err_t                err_reg, err_next;
    logic                chg_reg, chg_next;
    logic [FILL_W-1:0]   ofill_reg, ofill_next;
    logic                last_reg, last_next;

    logic                slot_free;
    logic                accept;
    logic [CNT_W-1:0]    fill_ext;
    logic [FW-1:0]       n_rd;
    logic                load;

    assign slot_free = !valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign fill_ext  = CNT_W'(fill_reg);
    assign n_rd      = (count < fill_ext) ? FW'(count) : fill_reg;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rd_left_next  = rd_left_reg;
        rot_left_next = rot_left_reg;
        op            = OP_HOLD;
        load          = 1'b0;
        data_next     = '0;
        dv_next       = 1'b0;
        err_next      = ERR_NONE;
        chg_next      = 1'b0;
        last_next     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_PUSH:
                        begin
                            if (fill_reg == FW'(DEPTH))
                                err_next = ERR_FULL;
                            else
                            begin
                                op        = OP_PUSH;
                                fill_next = fill_reg + 1'b1;
                                chg_next  = !quiet;
                            end
                        end
                        CMD_POP:
                        begin
                            if (fill_reg == '0)
                                err_next = ERR_EMPTY;
                            else
                            begin
                                op        = OP_POP;
                                fill_next = fill_reg - 1'b1;
                                data_next = top;
                                dv_next   = 1'b1;
                                chg_next  = !quiet;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (fill_reg < FW'(2))
                                err_next = ERR_FEW;
                            else
                            begin
                                op       = OP_SWAP;
                                chg_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            chg_next  = 1'b1;
                        end
                        CMD_READ:
                        begin
                            if (n_rd != '0)
                            begin
                                op            = OP_ROT;
                                data_next     = top;
                                dv_next       = 1'b1;
                                last_next     = (n_rd == FW'(1));
                                rd_left_next  = n_rd - 1'b1;
                                rot_left_next = fill_reg - 1'b1;
                                // keep rotating until the chain is back in order
                                if (fill_reg != FW'(1))
                                    state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (rd_left_reg != '0)
                begin
                    if (slot_free)
                    begin
                        op            = OP_ROT;
                        load          = 1'b1;
                        data_next     = top;
                        dv_next       = 1'b1;
                        last_next     = (rd_left_reg == FW'(1));
                        rd_left_next  = rd_left_reg - 1'b1;
                        rot_left_next = rot_left_reg - 1'b1;
                        if (rot_left_reg == FW'(1))
                            state_next = ST_IDLE;
                    end
                end
                else
                begin
                    op            = OP_ROT;
                    rot_left_next = rot_left_reg - 1'b1;
                    if (rot_left_reg == FW'(1))
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        ofill_next = FILL_W'(fill_next);
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            rd_left_reg  <= '0;
            rot_left_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_left_reg  <= rd_left_next;
            rot_left_reg <= rot_left_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= data_next;
            dv_reg    <= dv_next;
            err_reg   <= err_next;
            chg_reg   <= chg_next;
            ofill_reg <= ofill_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_dv    = dv_reg;
    assign out_err   = err_reg;
    assign out_chg   = chg_reg;
    assign out_fill  = ofill_reg;
    assign out_last  = last_reg;
    assign fill      = fill_reg;

endmodule

@@ rtl/operand_stack_with_swap_top.sv @@
`timescale 1ns / 1ps

// Bounded LIFO of 64-bit words built as a row of DEPTH cells, cell 0 holding the
// top; push, pop and swap shift or exchange words between neighbors. Push, pop,
// swap, clear, unused commands and reads with nothing to return each give one
// result word. A read of n entries with f entries on the stack gives the lesser
// of n and f data words at one per cycle while the output is not stalled, top
// first, and the cell row rotates one place per word; the block then keeps
// rotating until f rotations have restored the order, and only then is the next
// command word taken. Each read word waits for a free output register, so
// master-side stalls stretch a read. Results sit in one output register: a new
// command word is taken no earlier than the cycle in which the previous result
// word leaves on the master side, and a stalled result holds the slave side.

module operand_stack_with_swap_top
    import ostk_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // value[63:0], quiet[64], count[71:65]
    input  logic [CMD_W-1:0]      s_tuser,   // cmd[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // data[63:0], error[65:64], changed[66],
                                             // fill[73:67], zero[79:74]
    output logic [0:0]            m_tuser,   // data_valid[0]
    output logic                  m_tlast
);

    localparam int FW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] words [DEPTH];
    cell_ctrl_t        ctrl  [DEPTH];
    cell_op_t          op;
    logic [FW-1:0]     fill;
    logic [WORD_W-1:0] out_data;
    logic              out_dv;
    logic [ERR_W-1:0]  out_err;
    logic              out_chg;
    logic [FILL_W-1:0] out_fill;

    ostk_seq #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tuser),
        .quiet     (s_tdata[64]),
        .count     (s_tdata[71:65]),
        .top       (words[0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_dv    (out_dv),
        .out_err   (out_err),
        .out_chg   (out_chg),
        .out_fill  (out_fill),
        .out_last  (m_tlast),
        .op        (op),
        .fill      (fill)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next_w;

        assign ctrl[i].op   = op;
        assign ctrl[i].wrap = (fill == FW'(i + 1));

        if (i == 0)
        begin : g_first
            assign prev_w = s_tdata[WORD_W-1:0];
        end
        else
        begin : g_mid
            assign prev_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_inner
            assign next_w = words[i+1];
        end

        ostk_cell #(
            .IDX (i)
        ) u_cell (
            .clk  (clk),
            .ctrl (ctrl[i]),
            .prev (prev_w),
            .next (next_w),
            .top  (words[0]),
            .word (words[i])
        );
    end

    assign m_tdata = {6'b0, out_fill, out_chg, out_err, out_data};
    assign m_tuser = out_dv;

endmodule

@@ rtl/ostk_chk.sv @@
`timescale 1ns / 1ps

module ostk_chk
    import ostk_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [0:0]          m_tuser,
    input  logic                m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[WORD_W-1:0] == '0)
        else $error("data nonzero without data_valid");

    // an error ends the command and changes nothing
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65:64] != ERR_NONE |-> m_tlast && !m_tdata[66]
            && !m_tuser[0])
        else $error("error result malformed");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[73:67] <= FILL_W'(DEPTH))
        else $error("fill beyond depth");

endmodule

bind operand_stack_with_swap_top ostk_chk #(
    .DEPTH (DEPTH)
) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
